// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// shared widths, register indexes and arithmetic constants of the 3x3 box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

    // line store depth and the column counter that addresses it
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    // frame height bound and the row counter
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int MEAN_W     = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // column sum of three pixels and window sum of three columns
    localparam int CSUM_W     = PIX_W + 2;
    localparam int WSUM_W     = PIX_W + 4;

    // division by 9 as multiply by ceil(2^19/9), exact for 16*sum+4 < 74898
    localparam int DIV_X_W    = WSUM_W + 4;
    localparam int RECIP_SH   = 19;
    localparam int RECIP_W    = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = 16'd58255;
    localparam int PROD_W     = DIV_X_W + RECIP_W;

    // rounding offset added before the divide
    localparam logic [DIV_X_W-1:0] ROUND_OFS = 16'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // reset values of the registers
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1000;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1000;

endpackage

// ===== rtl/box_blur_3x3_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_core
// 3x3 box filter over a raster pixel stream, valid region output only
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and, for every pixel at
// column >= 2 and row >= 2, returns the mean of the 3x3 neighbourhood ending
// there as unsigned Q8.4, rounded; last_of_frame marks the final result of a
// frame. The sustained rate is one pixel per clock unless results stall: both
// line stores are read at the incoming column in the accept cycle and written
// back as the pixel leaves stage 1, at a different column, so each store port
// serves one pixel a cycle. Results pass stage 1, stage 2 and the output
// register. Width and height are clamped to 3..1024 and 3..4096 and must only
// be written while the block is idle; the line stores need no clearing pass.
module box_blur_3x3_core
    import bb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // pixel input channel
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel,

    // result output channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [MEAN_W-1:0]     mean_q4,
    output logic                  last_of_frame
);

    // configuration registers
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;

    // position counters
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    // line stores and their registered read data
    logic [PIX_W-1:0]    line_a [MAX_WIDTH];
    logic [PIX_W-1:0]    line_b [MAX_WIDTH];
    logic [PIX_W-1:0]    rd_a_reg;
    logic [PIX_W-1:0]    rd_b_reg;

    // stage 1: pixel waiting on its line store read
    logic                s1_valid_reg;
    logic [PIX_W-1:0]    s1_pixel_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;

    // window kept as the column sums of its two older columns
    logic [CSUM_W-1:0]   win_col1_reg;
    logic [CSUM_W-1:0]   win_col2_reg;

    // stage 2: window sum
    logic                s2_valid_reg;
    logic [WSUM_W-1:0]   s2_sum_reg;
    logic                s2_last_reg;

    // output register
    logic                out_valid_reg;
    logic [MEAN_W-1:0]   out_mean_reg;
    logic                out_last_reg;

    // flow control
    logic                rdy1, rdy2, rdy3;
    logic                accept, adv1;

    // row and frame bounds
    logic [COL_W-1:0]    col_lim;
    logic [ROW_W-1:0]    row_lim;
    logic                row_end, frame_end, emit;

    // datapath
    logic [CSUM_W-1:0]   col_sum;
    logic [WSUM_W-1:0]   win_sum;
    logic [DIV_X_W-1:0]  div_x;
    logic [PROD_W-1:0]   prod;

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // pipeline handshake, a stage moves when the one after it has room
    assign rdy3        = !out_valid_reg || !result_stall;
    assign rdy2        = !s2_valid_reg || rdy3;
    assign rdy1        = !s1_valid_reg || rdy2;
    assign pixel_stall = !rdy1;
    assign accept      = pixel_valid && rdy1;
    assign adv1        = s1_valid_reg && rdy2;

    // clamped last column and last row
    always_comb
    begin
        if (image_width_reg < WIDTH_W'(3))
            col_lim = COL_W'(2);
        else if (image_width_reg > WIDTH_W'(MAX_WIDTH))
            col_lim = COL_W'(MAX_WIDTH - 1);
        else
            col_lim = COL_W'(image_width_reg - WIDTH_W'(1));

        if (image_height_reg < HEIGHT_W'(3))
            row_lim = ROW_W'(2);
        else if (image_height_reg > HEIGHT_W'(MAX_HEIGHT))
            row_lim = ROW_W'(MAX_HEIGHT - 1);
        else
            row_lim = ROW_W'(image_height_reg - HEIGHT_W'(1));
    end

    assign row_end   = col_reg >= col_lim;
    assign frame_end = row_end && (row_reg >= row_lim);
    assign emit      = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));

    // counter update, wraps at row and frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: read on accept, write back when the pixel leaves stage 1;
    // back to back pixels always sit at different columns, so a read never
    // meets the pending write of the same entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_a_reg <= line_a[col_reg];
            rd_b_reg <= line_b[col_reg];
        end
        if (adv1)
        begin
            line_a[s1_col_reg] <= s1_pixel_reg;
            line_b[s1_col_reg] <= rd_a_reg;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rdy1)
            s1_valid_reg <= accept;
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_emit_reg  <= emit;
            s1_last_reg  <= frame_end;
        end
    end

    // newest column and window sum
    assign col_sum = CSUM_W'(rd_b_reg) + CSUM_W'(rd_a_reg) + CSUM_W'(s1_pixel_reg);
    assign win_sum = WSUM_W'(win_col1_reg) + WSUM_W'(win_col2_reg) + WSUM_W'(col_sum);

    // window shift, one column per pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_col1_reg <= '0;
            win_col2_reg <= '0;
        end
        else if (adv1)
        begin
            win_col1_reg <= win_col2_reg;
            win_col2_reg <= col_sum;
        end
    end

    // stage 2 control, only pixels that produce a result go on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= adv1 && s1_emit_reg;
    end

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_sum_reg  <= win_sum;
            s2_last_reg <= s1_last_reg;
        end
    end

    // rounded divide by 9 through the reciprocal
    assign div_x = {s2_sum_reg, 4'b0000} + ROUND_OFS;
    assign prod  = PROD_W'(div_x) * PROD_W'(RECIP_9);

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy3)
            out_valid_reg <= s2_valid_reg;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            out_mean_reg <= prod[RECIP_SH +: MEAN_W];
            out_last_reg <= s2_last_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign mean_q4       = out_mean_reg;
    assign last_of_frame = out_last_reg;

endmodule

// ===== rtl/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// port level checks of the 3x3 box blur, bound to the top level
// ----------------------------------------------------------------------------
module bb3_checker
    import bb3_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  pixel_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [MEAN_W-1:0]     mean_q4,
    input logic                  last_of_frame
);

    // input backpressure only comes from a blocked result
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid && result_stall))
        else $error("pixel stall without a blocked result");

    // a blocked result holds its transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(mean_q4) && $stable(last_of_frame)))
        else $error("stalled result changed");

    // the mean of 8-bit pixels never exceeds 255 in Q8.4
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (mean_q4 <= 12'd4080))
        else $error("mean out of range");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind box_blur_3x3_core bb3_checker u_bb3_checker (.*);

// ===== test/tb_box_blur_3x3_core.sv =====
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_core
// self-checking bench for the 3x3 box blur over a raster pixel stream
// ----------------------------------------------------------------------------
// Streams pixel frames of many sizes into the core and predicts every blurred
// pixel with a line-store and window model of its own. A clocked driver feeds
// pixels from a queue and a clocked monitor compares each mean_q4 and
// last_of_frame with the oldest prediction. Frame size is changed only while
// the core is idle, both at frame boundaries and in the middle of a frame,
// with values below, at and above the legal range. Both channels idle in
// random bursts, and long result holds back-pressure the pixel input.
`timescale 1ns / 100ps

module tb_box_blur_3x3_core;
    import bb3_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 150;
    localparam int FILL_WIDTH   = 32;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_q4;
        logic              last_of_frame;
    } blur_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [MEAN_W-1:0]     mean_q4;
    logic                  last_of_frame;

    // pixels waiting to be sent and blurred pixels waiting to arrive
    logic [PIX_W-1:0] pixel_queue[$];
    blur_result_t     mean_queue[$];
    blur_result_t     want;

    // predictor state: two rows above, 3x3 window, raster counters, frame size
    logic [PIX_W-1:0]    row_one_up[MAX_WIDTH];
    logic [PIX_W-1:0]    row_two_up[MAX_WIDTH];
    logic [PIX_W-1:0]    win[9];
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // run control and bookkeeping
    logic quiet = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_reqs = 0;
    int   hold_grants = 0;
    int   pixels_pushed = 0;
    int   pixels_taken = 0;
    int   means_checked = 0;
    int   frames_closed = 0;
    int   reg_writes = 0;
    int   fail_count = 0;

    box_blur_3x3_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .mean_q4       (mean_q4),
        .last_of_frame (last_of_frame)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // effective row length after range limiting
    function automatic int unsigned clamp_width(input logic [WIDTH_W-1:0] w);
        if (w < 3)
            return 3;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return w;
    endfunction

    // advance the blur model by one pixel and queue the mean it produces
    function automatic void box_mean_step(input logic [PIX_W-1:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  col;
        int unsigned  idx;
        int unsigned  total;
        int           k;
        logic [PIX_W-1:0] up2;
        logic [PIX_W-1:0] up1;
        logic         row_end;
        logic         frame_end;
        blur_result_t res;

        w = clamp_width(width_reg);
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        col = col_cnt;
        idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
        up2 = row_two_up[idx];
        up1 = row_one_up[idx];
        row_end = (col >= w - 1);
        frame_end = row_end && (row_cnt >= h - 1);

        row_two_up[idx] = up1;
        row_one_up[idx] = px;

        // shift in the new column: top, middle, bottom
        for (k = 0; k < 6; k++)
            win[k] = win[k + 3];
        win[6] = up2;
        win[7] = up1;
        win[8] = px;

        // only neighbourhoods fully inside the frame give a result
        if (col >= 2 && row_cnt >= 2)
        begin
            total = 0;
            for (k = 0; k < 9; k++)
                total += win[k];
            res.mean_q4 = MEAN_W'((total * 16 + 4) / 9);
            res.last_of_frame = frame_end;
            mean_queue.push_back(res);
        end

        if (row_end)
        begin
            col_cnt = 0;
            row_cnt = frame_end ? 0 : row_cnt + 1;
        end
        else
        begin
            col_cnt = col + 1;
        end
    endfunction

    // pixel values: full range, black/white only, or near white
    function automatic logic [PIX_W-1:0] random_pixel(input int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1: return PIX_W'($urandom_range(240, 255));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_pixel(input logic [PIX_W-1:0] px);
        pixel_queue.push_back(px);
        pixels_pushed++;
    endfunction

    // wait for every pixel to be taken and every mean to arrive, then settle
    task automatic drain_pipeline();
        while (pixels_taken != pixels_pushed || mean_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write both frame size registers, one transaction each
    task automatic write_frame_size(input logic [CFG_DATA_W-1:0] width_data,
                                    input logic [CFG_DATA_W-1:0] height_data);
        cfg_valid <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= width_data;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= height_data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // pixel driver: random gap bursts, payload held while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
        end
        else if (!pixel_valid || !pixel_stall)
        begin
            if (gap_left != 0)
            begin
                pixel_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                pixel_valid <= 1'b0;
                gap_left <= $urandom_range(0, 4);
            end
            else if (pixel_queue.size() != 0)
            begin
                pixel_valid <= 1'b1;
                pixel <= pixel_queue.pop_front();
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // result stall: long holds on request, otherwise random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_grants)
        begin
            result_stall <= 1'b1;
            hold_grants <= hold_grants + 1;
            hold_left <= LONG_HOLD;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // monitor: check each result transaction, feed the model on accepted input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (mean_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: mean_q4=%0d last_of_frame=%0d",
                                 mean_q4, last_of_frame);
                end
                else
                begin
                    want = mean_queue.pop_front();
                    if (mean_q4 !== want.mean_q4 || last_of_frame !== want.last_of_frame)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: want mean %0d last %0d, got mean %0d last %0d",
                                     means_checked, want.mean_q4, want.last_of_frame,
                                     mean_q4, last_of_frame);
                    end
                    means_checked++;
                    if (want.last_of_frame)
                        frames_closed++;
                end
            end

            if (pixel_valid && !pixel_stall)
            begin
                box_mean_step(pixel);
                pixels_taken++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
                reg_writes++;
            end
        end
    end

    // stimulus
    initial
    begin
        int                    random_items;
        int                    n;
        int                    mode;
        int                    pick;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        random_items = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_one_up[i] = '0;
            row_two_up[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame size: part of the first row only
        repeat (12) push_pixel(random_pixel(2));
        drain_pipeline();

        // shrink both sizes mid-row: the row wraps at once, the frame closes two rows on
        write_frame_size(13'd0, 13'd2);
        push_pixel(8'hA5);
        repeat (6) push_pixel(random_pixel(2));
        drain_pipeline();

        // width above range, height below, left in the middle of the first row
        write_frame_size(13'd2047, 13'd1);
        repeat (20) push_pixel(random_pixel(2));
        drain_pipeline();

        // widest random width: finishes that row and fills both line stores up to it
        write_frame_size(CFG_DATA_W'(FILL_WIDTH), 13'd4);
        repeat (4 * FILL_WIDTH - 20) push_pixel(random_pixel(2));
        while (mean_queue.size() == 0)
            @(posedge clk);
        hold_reqs++;
        drain_pipeline();

        // smallest frame at pixel extremes
        write_frame_size(13'd3, 13'd3);
        repeat (9) push_pixel(8'hFF);
        repeat (9) push_pixel(8'h00);
        drain_pipeline();
        write_frame_size(13'd1, 13'd0);
        for (int i = 0; i < 9; i++)
            push_pixel((i % 2) ? 8'hFF : 8'h00);
        drain_pipeline();

        // tallest frame, left mid-frame; width data with bits above the register set
        write_frame_size({2'b11, 11'd3}, 13'd4096);
        repeat (30) push_pixel(random_pixel($urandom_range(0, 3)));
        while (mean_queue.size() == 0)
            @(posedge clk);
        hold_reqs++;
        drain_pipeline();

        // random phases, mostly small frames, size changes often mid-frame
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            drain_pipeline();
            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    wdata = CFG_DATA_W'($urandom_range(0, 2));
                else if (pick == 1)
                    wdata = CFG_DATA_W'($urandom_range(13, FILL_WIDTH));
                else
                    wdata = CFG_DATA_W'($urandom_range(3, 12));
                if ($urandom_range(0, 7) == 0)
                    wdata[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W - WIDTH_W)'($urandom_range(1, 3));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    hdata = CFG_DATA_W'($urandom_range(0, 2));
                else if (pick == 1)
                    hdata = CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
                else if (pick == 2)
                    hdata = CFG_DATA_W'($urandom_range(7, 30));
                else
                    hdata = CFG_DATA_W'($urandom_range(3, 6));
                write_frame_size(wdata, hdata);
            end
            n = $urandom_range(1, 3 * clamp_width(width_reg) + 30);
            if (n > RANDOM_ITEMS - random_items)
                n = RANDOM_ITEMS - random_items;
            mode = $urandom_range(0, 5);
            repeat (n) push_pixel(random_pixel(mode));
            random_items += n;
        end
        drain_pipeline();

        $display("sent %0d pixels, checked %0d blurred pixels over %0d closed frames",
                 pixels_taken, means_checked, frames_closed);
        $display("frame size written %0d times, including out-of-range and mid-frame sizes",
                 reg_writes);
        if (fail_count == 0 && mean_queue.size() == 0)
            $display("box_blur_3x3_core: match");
        else
            $display("box_blur_3x3_core: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("box_blur_3x3_core: mismatch");
        $finish;
    end

endmodule

// ===== box_blur_3x3_core.f =====
rtl/bb3_pkg.sv
rtl/box_blur_3x3_core.sv
rtl/bb3_checker.sv
test/tb_box_blur_3x3_core.sv
